>>> rtl/core/rlgr_pkg.sv
`default_nettype none

package rlgr_pkg;

   localparam int ValueBits = 16;
   localparam int ParamBits = 4;
   localparam int AccBits   = 6;
   localparam int CountBits = 16;
   localparam int RunBits   = 15;
   localparam int RemBits   = 15;
   localparam int CsrBits   = 6;
   localparam int IndexBits = 3;

   localparam logic [ParamBits-1:0] MaxParam = 4'd15;
   localparam logic [AccBits-1:0]   AccMax   = 6'd63;

   typedef enum logic [1:0] {
      CODE_RUN     = 2'd0,
      CODE_RICE    = 2'd1,
      CODE_PARTIAL = 2'd2
   } code_kind_type;

   typedef enum logic [IndexBits-1:0] {
      REG_UP_NO_RUN     = 3'd0,
      REG_DOWN_NO_RUN   = 3'd1,
      REG_UP_RUN        = 3'd2,
      REG_DOWN_RUN      = 3'd3,
      REG_SCALE_SHIFT   = 3'd4,
      REG_RUN_ACC_INIT  = 3'd5,
      REG_RICE_ACC_INIT = 3'd6
   } reg_index_type;

endpackage

`default_nettype wire

>>> rtl/core/rlgr_req_if.sv
`default_nettype none

interface rlgr_req_if;
   logic                            valid;
   logic                            ready;
   logic [rlgr_pkg::ValueBits-1:0]  value;
   logic                            last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rlgr_rsp_if.sv
`default_nettype none

interface rlgr_rsp_if;
   logic                            valid;
   logic                            ready;
   rlgr_pkg::code_kind_type         code_kind;
   logic [rlgr_pkg::RunBits-1:0]    run_count;
   logic [rlgr_pkg::ParamBits-1:0]  run_count_bits;
   logic [rlgr_pkg::ValueBits-1:0]  unary_len;
   logic [rlgr_pkg::RemBits-1:0]    remainder;
   logic [rlgr_pkg::ParamBits-1:0]  remainder_bits;

   modport source (output valid, output code_kind, output run_count, output run_count_bits,
                   output unary_len, output remainder, output remainder_bits, input ready);
   modport sink   (input valid, input code_kind, input run_count, input run_count_bits,
                   input unary_len, input remainder, input remainder_bits, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rlgr_adaptive_encoder.sv
// Adaptive run-length Golomb-Rice encoder. Takes one value per cycle and gives at most
// one code token per value. A value passes the input register, then the result register,
// before its token is valid. A token waiting at the output holds the value in the input
// register, so the input stalls once that register is full. Sustained rate is one item per
// clock while the output is not stalled; the accumulators, run parameter and zero count update
// with each item. A zero that does not finish a run gives no token; an item with last set
// flushes a pending run, loads the accumulators from the init registers and clears the run
// parameter and zero count. Write the configuration registers only while the block is idle.
`default_nettype none

module rlgr_adaptive_encoder (
   input  wire logic                             clock,
   input  wire logic                             reset,
   rlgr_req_if.sink                              req_ch,
   rlgr_rsp_if.source                            rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [rlgr_pkg::IndexBits-1:0]   csr_index,
   input  wire logic [rlgr_pkg::CsrBits-1:0]     csr_wdata
);

   localparam int VB = rlgr_pkg::ValueBits;
   localparam int PB = rlgr_pkg::ParamBits;
   localparam int AB = rlgr_pkg::AccBits;
   localparam int CB = rlgr_pkg::CountBits;

   function automatic logic [PB-1:0] scaled(input logic [AB-1:0] acc, input logic [1:0] sh);
      logic [AB-1:0] v;
      v = acc >> sh;
      return (v > AB'(rlgr_pkg::MaxParam)) ? rlgr_pkg::MaxParam : v[PB-1:0];
   endfunction

   function automatic logic [AB-1:0] acc_add(input logic [AB-1:0] a, input logic [VB:0] d);
      logic [VB+1:0] s;
      s = (VB+2)'(a) + (VB+2)'(d);
      return (s > (VB+2)'(rlgr_pkg::AccMax)) ? rlgr_pkg::AccMax : s[AB-1:0];
   endfunction

   function automatic logic [AB-1:0] acc_sub(input logic [AB-1:0] a, input logic [AB-1:0] d);
      return (a > d) ? a - d : '0;
   endfunction

   // configuration
   logic [3:0]    up_no_run_ff, down_no_run_ff, up_run_ff, down_run_ff;
   logic [1:0]    scale_shift_ff;
   logic [AB-1:0] run_acc_init_ff, rice_acc_init_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         up_no_run_ff     <= 4'd3;
         down_no_run_ff   <= 4'd1;
         up_run_ff        <= 4'd2;
         down_run_ff      <= 4'd1;
         scale_shift_ff   <= 2'd2;
         run_acc_init_ff  <= 6'd16;
         rice_acc_init_ff <= 6'd16;
      end else if (csr_we) begin
         unique case (csr_index)
            rlgr_pkg::REG_UP_NO_RUN:     up_no_run_ff     <= csr_wdata[3:0];
            rlgr_pkg::REG_DOWN_NO_RUN:   down_no_run_ff   <= csr_wdata[3:0];
            rlgr_pkg::REG_UP_RUN:        up_run_ff        <= csr_wdata[3:0];
            rlgr_pkg::REG_DOWN_RUN:      down_run_ff      <= csr_wdata[3:0];
            rlgr_pkg::REG_SCALE_SHIFT:   scale_shift_ff   <= csr_wdata[1:0];
            rlgr_pkg::REG_RUN_ACC_INIT:  run_acc_init_ff  <= csr_wdata;
            rlgr_pkg::REG_RICE_ACC_INIT: rice_acc_init_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   logic          in_valid_ff, in_valid_in;
   logic [VB-1:0] in_value_ff;
   logic          in_last_ff;
   logic          out_valid_ff, out_valid_in;
   logic          advance;
   logic          req_accept;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_accept   = req_ch.valid && req_ch.ready;

   always_comb begin
      if (req_accept) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      else in_valid_in = in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) begin
         in_value_ff <= req_ch.value;
         in_last_ff  <= req_ch.last;
      end
   end

   // coding state
   logic [AB-1:0] run_acc_ff, run_acc_in, rice_acc_ff, rice_acc_in;
   logic [PB-1:0] run_param_ff, run_param_in;
   logic [CB-1:0] zero_count_ff, zero_count_in;

   logic          value_zero;
   logic [VB-1:0] rice_value;
   logic [PB-1:0] kr;
   logic [VB-1:0] quotient;
   logic [VB-1:0] rem_full;
   logic [AB-1:0] rice_acc_adapt;
   logic [CB:0]   zero_inc;
   logic          run_done;
   logic [AB-1:0] run_acc_upd;
   logic          run_upd;
   logic          produce;
   rlgr_pkg::code_kind_type kind;

   assign value_zero = (in_value_ff == '0);
   assign rice_value = (run_param_ff == '0) ? in_value_ff : in_value_ff - VB'(1);
   assign kr         = scaled(rice_acc_ff, scale_shift_ff);
   assign quotient   = rice_value >> kr;
   assign rem_full   = rice_value & ((VB'(1) << kr) - VB'(1));
   assign zero_inc   = (CB+1)'(zero_count_ff) + (CB+1)'(1);
   assign run_done   = (zero_inc >= ((CB+1)'(1) << run_param_ff)) || in_last_ff;

   always_comb begin
      if (quotient == '0) rice_acc_adapt = acc_sub(rice_acc_ff, AB'(2));
      else if (quotient == VB'(1)) rice_acc_adapt = rice_acc_ff;
      else rice_acc_adapt = acc_add(rice_acc_ff, (VB+1)'(quotient) + (VB+1)'(1));
   end

   always_comb begin
      run_acc_upd   = run_acc_ff;
      run_upd       = 1'b0;
      rice_acc_in   = rice_acc_ff;
      zero_count_in = zero_count_ff;
      produce       = 1'b1;
      kind          = rlgr_pkg::CODE_RICE;
      if (run_param_ff == '0) begin
         rice_acc_in = rice_acc_adapt;
         run_upd     = 1'b1;
         run_acc_upd = value_zero ? acc_add(run_acc_ff, (VB+1)'(up_no_run_ff))
                                  : acc_sub(run_acc_ff, AB'(down_no_run_ff));
      end else if (value_zero) begin
         kind = rlgr_pkg::CODE_RUN;
         if (run_done) begin
            zero_count_in = '0;
            run_upd       = 1'b1;
            run_acc_upd   = acc_add(run_acc_ff, (VB+1)'(up_run_ff));
         end else begin
            zero_count_in = zero_inc[CB-1:0];
            produce       = 1'b0;
         end
      end else begin
         kind          = rlgr_pkg::CODE_PARTIAL;
         rice_acc_in   = rice_acc_adapt;
         zero_count_in = '0;
         run_upd       = 1'b1;
         run_acc_upd   = acc_sub(run_acc_ff, AB'(down_run_ff));
      end
      run_acc_in   = run_acc_upd;
      run_param_in = run_upd ? scaled(run_acc_upd, scale_shift_ff) : run_param_ff;
      if (in_last_ff) begin
         run_acc_in    = run_acc_init_ff;
         rice_acc_in   = rice_acc_init_ff;
         run_param_in  = '0;
         zero_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_acc_ff    <= 6'd16;
         rice_acc_ff   <= 6'd16;
         run_param_ff  <= '0;
         zero_count_ff <= '0;
      end else if (advance) begin
         run_acc_ff    <= run_acc_in;
         rice_acc_ff   <= rice_acc_in;
         run_param_ff  <= run_param_in;
         zero_count_ff <= zero_count_in;
      end
   end

   // result register
   rlgr_pkg::code_kind_type          code_kind_ff;
   logic [rlgr_pkg::RunBits-1:0]     run_count_ff;
   logic [PB-1:0]                    run_count_bits_ff;
   logic [VB-1:0]                    unary_len_ff;
   logic [rlgr_pkg::RemBits-1:0]     remainder_ff;
   logic [PB-1:0]                    remainder_bits_ff;

   always_comb begin
      if (advance) out_valid_in = produce;
      else if (rsp_ch.ready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance && produce) begin
         code_kind_ff      <= kind;
         run_count_ff      <= '0;
         run_count_bits_ff <= '0;
         unary_len_ff      <= '0;
         remainder_ff      <= '0;
         remainder_bits_ff <= '0;
         if (kind != rlgr_pkg::CODE_RUN) begin
            unary_len_ff      <= quotient;
            remainder_ff      <= rem_full[rlgr_pkg::RemBits-1:0];
            remainder_bits_ff <= kr;
         end
         if (kind == rlgr_pkg::CODE_PARTIAL) begin
            run_count_ff      <= zero_count_ff[rlgr_pkg::RunBits-1:0];
            run_count_bits_ff <= run_param_ff;
         end
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.code_kind      = code_kind_ff;
   assign rsp_ch.run_count      = run_count_ff;
   assign rsp_ch.run_count_bits = run_count_bits_ff;
   assign rsp_ch.unary_len      = unary_len_ff;
   assign rsp_ch.remainder      = remainder_ff;
   assign rsp_ch.remainder_bits = remainder_bits_ff;

   // checks
   a_no_count_in_rice_mode: assert property (@(posedge clock) disable iff (reset)
      run_param_ff == '0 |-> zero_count_ff == '0)
      else $error("zero count pending while run parameter is zero");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> run_param_ff == '0 && zero_count_ff == '0)
      else $error("state not restarted after last item");

   a_run_token_empty: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && code_kind_ff == rlgr_pkg::CODE_RUN |->
         unary_len_ff == '0 && remainder_bits_ff == '0 && run_count_bits_ff == '0)
      else $error("complete-run token carries fields");

   a_rice_token_no_run: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && code_kind_ff == rlgr_pkg::CODE_RICE |->
         run_count_ff == '0 && run_count_bits_ff == '0)
      else $error("plain Rice token carries a run count");

endmodule

`default_nettype wire
